[hdl/pms_pkg.sv]
// Package for the PID mass-spring step block: word format, register map,
// datapath command encoding and controller states. No dependencies.
package pms_pkg;

  // Q16.16 signed word
  localparam int WordW  = 32;
  localparam int FracW  = 16;
  // gain register widths
  localparam int GainW  = 31;
  localparam int RatioW = 17;
  // full product of a word magnitude and a gain
  localparam int ProdW  = WordW + GainW;
  localparam int QuotW  = ProdW - FracW;

  // configuration port
  localparam int NumRegs = 8;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int IdxW    = $clog2(NumRegs);

  // register reset values
  localparam logic [GainW-1:0]  KpRst    = GainW'(2621440);
  localparam logic [GainW-1:0]  KiDtRst  = GainW'(6554);
  localparam logic [GainW-1:0]  KdRst    = GainW'(1310720);
  localparam logic [RatioW-1:0] AlphaRst = RatioW'(6554);
  localparam logic [GainW-1:0]  ForceRst = GainW'(131);
  localparam logic [GainW-1:0]  SpringRst = GainW'(1311);
  localparam logic [GainW-1:0]  DampRst  = GainW'(262);
  localparam logic [RatioW-1:0] StepRst  = RatioW'(655);

  // register indexes; also used to pick the multiplier gain
  typedef enum logic [IdxW-1:0] {
    REG_KP,
    REG_KI_DT,
    REG_KD,
    REG_ALPHA,
    REG_FORCE,
    REG_SPRING,
    REG_DAMP,
    REG_STEP
  } reg_e;

  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki_dt;
    logic [GainW-1:0]  kd;
    logic [RatioW-1:0] alpha;
    logic [GainW-1:0]  force_rate;
    logic [GainW-1:0]  spring_rate;
    logic [GainW-1:0]  damping_rate;
    logic [RatioW-1:0] time_step;
  } gains_t;

  // datapath operand sources
  typedef enum logic [3:0] {
    OPD_TARGET,
    OPD_ERR,
    OPD_SUM,
    OPD_DRIVE,
    OPD_PULL,
    OPD_FORCE,
    OPD_ACC,
    OPD_VEL,
    OPD_DISP,
    OPD_MQ,
    OPD_MQ_PREV
  } opd_e;

  // adder destinations
  typedef enum logic [3:0] {
    DST_NONE,
    DST_ERR,
    DST_SUM,
    DST_DRIVE,
    DST_PULL,
    DST_FORCE,
    DST_ACC,
    DST_VEL,
    DST_DISP
  } dst_e;

  typedef struct packed {
    logic start;     // first step of an item: restart the clip flag
    dst_e alu_dst;
    opd_e alu_a;
    opd_e alu_b;
    logic alu_sub;
    logic mul_go;
    opd_e mul_a;
    reg_e mul_gain;
    logic out_load;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_KI,
    ST_MUL_KD,
    ST_DRIVE,
    ST_DRIVE_KD,
    ST_PULL,
    ST_MUL_ALPHA,
    ST_WAIT_FORCE,
    ST_FORCE,
    ST_MUL_FR,
    ST_MUL_SR,
    ST_MUL_DR,
    ST_ACC,
    ST_ACC_DR,
    ST_VEL,
    ST_MUL_DT,
    ST_WAIT_DISP,
    ST_DISP,
    ST_DONE
  } st_e;

endpackage

[hdl/pms_if.sv]
// Stream interfaces for the input and result beats of the step block.
// Depends on pms_pkg for the word width.
interface pms_in_if;
  import pms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] target_offset;

  modport source (output valid, output target_offset, input ready);
  modport sink   (input valid, input target_offset, output ready);
endinterface

interface pms_out_if;
  import pms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] drive_value;
  logic signed [WordW-1:0] displacement_out;
  logic                    saturated;

  modport source (output valid, output drive_value, output displacement_out,
                  output saturated, input ready);
  modport sink   (input valid, input drive_value, input displacement_out,
                  input saturated, output ready);
endinterface

[hdl/pms_regs.sv]
// Configuration register bank behind the APB-style port.
// Depends on pms_pkg for the register map and reset values.
module pms_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [pms_pkg::AddrW-1:0] paddr,
  input  logic [pms_pkg::DataW-1:0] pwdata,
  output logic [pms_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output pms_pkg::gains_t          gains_o
);
  import pms_pkg::*;

  gains_t gains_q;
  reg_e   idx;
  logic   wr_en;

  assign idx    = reg_e'(paddr[IdxW+1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign gains_o = gains_q;

  // write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp           <= KpRst;
      gains_q.ki_dt        <= KiDtRst;
      gains_q.kd           <= KdRst;
      gains_q.alpha        <= AlphaRst;
      gains_q.force_rate   <= ForceRst;
      gains_q.spring_rate  <= SpringRst;
      gains_q.damping_rate <= DampRst;
      gains_q.time_step    <= StepRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP:     gains_q.kp           <= pwdata[GainW-1:0];
        REG_KI_DT:  gains_q.ki_dt        <= pwdata[GainW-1:0];
        REG_KD:     gains_q.kd           <= pwdata[GainW-1:0];
        REG_ALPHA:  gains_q.alpha        <= pwdata[RatioW-1:0];
        REG_FORCE:  gains_q.force_rate   <= pwdata[GainW-1:0];
        REG_SPRING: gains_q.spring_rate  <= pwdata[GainW-1:0];
        REG_DAMP:   gains_q.damping_rate <= pwdata[GainW-1:0];
        REG_STEP:   gains_q.time_step    <= pwdata[RatioW-1:0];
        default:    ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (idx)
      REG_KP:     prdata = DataW'(gains_q.kp);
      REG_KI_DT:  prdata = DataW'(gains_q.ki_dt);
      REG_KD:     prdata = DataW'(gains_q.kd);
      REG_ALPHA:  prdata = DataW'(gains_q.alpha);
      REG_FORCE:  prdata = DataW'(gains_q.force_rate);
      REG_SPRING: prdata = DataW'(gains_q.spring_rate);
      REG_DAMP:   prdata = DataW'(gains_q.damping_rate);
      REG_STEP:   prdata = DataW'(gains_q.time_step);
      default:    prdata = '0;
    endcase
  end

endmodule

[hdl/pms_ctrl.sv]
// Sequencer for one Euler step: walks the schedule of adder and multiplier
// commands and runs the input and result handshakes. Depends on pms_pkg.
module pms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pms_pkg::dp_cmd_t cmd_o
);
  import pms_pkg::*;

  st_e  state_q, state_d;
  logic out_valid_q, out_valid_d;

  // state and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.alu_dst = DST_NONE;
    cmd_o.alu_a   = OPD_ERR;
    cmd_o.alu_b   = OPD_ERR;
    cmd_o.mul_a   = OPD_ERR;
    cmd_o.mul_gain = REG_KP;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        // error = target - displacement on the accepting edge
        if (in_valid_i) begin
          cmd_o.start   = 1'b1;
          cmd_o.alu_dst = DST_ERR;
          cmd_o.alu_a   = OPD_TARGET;
          cmd_o.alu_b   = OPD_DISP;
          cmd_o.alu_sub = 1'b1;
          state_d       = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.alu_dst  = DST_SUM;
        cmd_o.alu_a    = OPD_SUM;
        cmd_o.alu_b    = OPD_ERR;
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_ERR;
        cmd_o.mul_gain = REG_KP;
        state_d        = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_SUM;
        cmd_o.mul_gain = REG_KI_DT;
        state_d        = ST_MUL_KD;
      end
      ST_MUL_KD: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_VEL;
        cmd_o.mul_gain = REG_KD;
        state_d        = ST_DRIVE;
      end
      ST_DRIVE: begin
        // proportional plus integral terms
        cmd_o.alu_dst = DST_DRIVE;
        cmd_o.alu_a   = OPD_MQ_PREV;
        cmd_o.alu_b   = OPD_MQ;
        state_d       = ST_DRIVE_KD;
      end
      ST_DRIVE_KD: begin
        cmd_o.alu_dst = DST_DRIVE;
        cmd_o.alu_a   = OPD_DRIVE;
        cmd_o.alu_b   = OPD_MQ;
        cmd_o.alu_sub = 1'b1;
        state_d       = ST_PULL;
      end
      ST_PULL: begin
        cmd_o.alu_dst = DST_PULL;
        cmd_o.alu_a   = OPD_DRIVE;
        cmd_o.alu_b   = OPD_FORCE;
        cmd_o.alu_sub = 1'b1;
        state_d       = ST_MUL_ALPHA;
      end
      ST_MUL_ALPHA: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_PULL;
        cmd_o.mul_gain = REG_ALPHA;
        state_d        = ST_WAIT_FORCE;
      end
      ST_WAIT_FORCE: state_d = ST_FORCE;
      ST_FORCE: begin
        cmd_o.alu_dst = DST_FORCE;
        cmd_o.alu_a   = OPD_FORCE;
        cmd_o.alu_b   = OPD_MQ;
        state_d       = ST_MUL_FR;
      end
      ST_MUL_FR: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_FORCE;
        cmd_o.mul_gain = REG_FORCE;
        state_d        = ST_MUL_SR;
      end
      ST_MUL_SR: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_DISP;
        cmd_o.mul_gain = REG_SPRING;
        state_d        = ST_MUL_DR;
      end
      ST_MUL_DR: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_VEL;
        cmd_o.mul_gain = REG_DAMP;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        // actuator term minus spring term
        cmd_o.alu_dst = DST_ACC;
        cmd_o.alu_a   = OPD_MQ_PREV;
        cmd_o.alu_b   = OPD_MQ;
        cmd_o.alu_sub = 1'b1;
        state_d       = ST_ACC_DR;
      end
      ST_ACC_DR: begin
        cmd_o.alu_dst = DST_ACC;
        cmd_o.alu_a   = OPD_ACC;
        cmd_o.alu_b   = OPD_MQ;
        cmd_o.alu_sub = 1'b1;
        state_d       = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.alu_dst = DST_VEL;
        cmd_o.alu_a   = OPD_VEL;
        cmd_o.alu_b   = OPD_ACC;
        state_d       = ST_MUL_DT;
      end
      ST_MUL_DT: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_a    = OPD_VEL;
        cmd_o.mul_gain = REG_STEP;
        state_d        = ST_WAIT_DISP;
      end
      ST_WAIT_DISP: state_d = ST_DISP;
      ST_DISP: begin
        cmd_o.alu_dst = DST_DISP;
        cmd_o.alu_a   = OPD_DISP;
        cmd_o.alu_b   = OPD_MQ;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result slot is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hdl/pms_dp.sv]
// Datapath of the step block: state registers, one saturating adder, one
// shared two-stage Q16.16 multiplier and the result registers. Uses pms_pkg.
module pms_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pms_pkg::dp_cmd_t               cmd_i,
  input  pms_pkg::gains_t                gains_i,
  input  logic signed [pms_pkg::WordW-1:0] target_offset_i,
  output logic signed [pms_pkg::WordW-1:0] drive_value_o,
  output logic signed [pms_pkg::WordW-1:0] displacement_out_o,
  output logic                           saturated_o
);
  import pms_pkg::*;

  typedef struct packed {
    logic signed [WordW-1:0] target;
    logic signed [WordW-1:0] err;
    logic signed [WordW-1:0] sum;
    logic signed [WordW-1:0] drive;
    logic signed [WordW-1:0] pull;
    logic signed [WordW-1:0] frc;
    logic signed [WordW-1:0] acc;
    logic signed [WordW-1:0] vel;
    logic signed [WordW-1:0] disp;
    logic signed [WordW-1:0] mq;
    logic signed [WordW-1:0] mq_prev;
  } opd_set_t;

  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

  function automatic logic signed [WordW-1:0] pick(opd_e sel, opd_set_t o);
    logic signed [WordW-1:0] v;
    unique case (sel)
      OPD_TARGET:  v = o.target;
      OPD_ERR:     v = o.err;
      OPD_SUM:     v = o.sum;
      OPD_DRIVE:   v = o.drive;
      OPD_PULL:    v = o.pull;
      OPD_FORCE:   v = o.frc;
      OPD_ACC:     v = o.acc;
      OPD_VEL:     v = o.vel;
      OPD_DISP:    v = o.disp;
      OPD_MQ:      v = o.mq;
      OPD_MQ_PREV: v = o.mq_prev;
      default:     v = '0;
    endcase
    return v;
  endfunction

  // machine state
  logic signed [WordW-1:0] sum_q, frc_q, vel_q, disp_q;
  // intermediate values of one step
  logic signed [WordW-1:0] err_q, drive_q, pull_q, acc_q;
  logic                    flag_q;

  // multiplier pipeline
  logic [ProdW-1:0]        prod_q;
  logic                    neg_q, mvld_q;
  logic signed [WordW-1:0] mq_q, mq_prev_q;

  opd_set_t                opd;
  logic signed [WordW-1:0] alu_a, alu_b, alu_res, mul_a;
  logic signed [WordW:0]   alu_wide;
  logic                    alu_act, alu_clip;
  logic [GainW-1:0]        gain;
  logic                    mul_neg;
  logic [WordW-1:0]        mag;
  logic [QuotW-1:0]        quot;
  logic [WordW-1:0]        limit, mres;
  logic                    mclip;

  assign opd = '{target:  target_offset_i, err: err_q, sum: sum_q, drive: drive_q,
                 pull: pull_q, frc: frc_q, acc: acc_q, vel: vel_q, disp: disp_q,
                 mq: mq_q, mq_prev: mq_prev_q};

  // saturating add or subtract
  assign alu_a    = pick(cmd_i.alu_a, opd);
  assign alu_b    = pick(cmd_i.alu_b, opd);
  assign alu_wide = cmd_i.alu_sub ? ({alu_a[WordW-1], alu_a} - {alu_b[WordW-1], alu_b})
                                  : ({alu_a[WordW-1], alu_a} + {alu_b[WordW-1], alu_b});
  assign alu_clip = alu_wide[WordW] != alu_wide[WordW-1];
  assign alu_res  = alu_clip ? (alu_wide[WordW] ? WordMin : WordMax)
                             : alu_wide[WordW-1:0];
  assign alu_act  = (cmd_i.alu_dst != DST_NONE);

  // multiplier first stage: magnitude times gain
  assign mul_a   = pick(cmd_i.mul_a, opd);
  assign mul_neg = mul_a[WordW-1];
  assign mag     = mul_neg ? WordW'(0 - $unsigned(mul_a)) : $unsigned(mul_a);

  always_comb begin
    unique case (cmd_i.mul_gain)
      REG_KP:     gain = gains_i.kp;
      REG_KI_DT:  gain = gains_i.ki_dt;
      REG_KD:     gain = gains_i.kd;
      REG_ALPHA:  gain = GainW'(gains_i.alpha);
      REG_FORCE:  gain = gains_i.force_rate;
      REG_SPRING: gain = gains_i.spring_rate;
      REG_DAMP:   gain = gains_i.damping_rate;
      REG_STEP:   gain = GainW'(gains_i.time_step);
      default:    gain = '0;
    endcase
  end

  // multiplier second stage: drop fraction, clip magnitude, restore sign
  assign quot  = prod_q[ProdW-1:FracW];
  assign limit = {1'b0, {(WordW-1){1'b1}}} + WordW'(neg_q);
  assign mclip = quot > QuotW'(limit);
  assign mres  = mclip ? limit : quot[WordW-1:0];

  // payload pipeline, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q    <= ProdW'(mag) * ProdW'(gain);
    neg_q     <= mul_neg;
    mq_q      <= neg_q ? $signed(WordW'(0 - mres)) : $signed(mres);
    mq_prev_q <= mq_q;
    if (alu_act) begin
      unique case (cmd_i.alu_dst)
        DST_ERR:   err_q   <= alu_res;
        DST_DRIVE: drive_q <= alu_res;
        DST_PULL:  pull_q  <= alu_res;
        DST_ACC:   acc_q   <= alu_res;
        default:   ;
      endcase
    end
    if (cmd_i.out_load) begin
      drive_value_o      <= drive_q;
      displacement_out_o <= disp_q;
      saturated_o        <= flag_q;
    end
  end

  // plant and controller state, clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      frc_q  <= '0;
      vel_q  <= '0;
      disp_q <= '0;
      mvld_q <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      mvld_q <= cmd_i.mul_go;
      if (cmd_i.start) begin
        flag_q <= alu_clip;
      end else begin
        flag_q <= flag_q | (alu_act & alu_clip) | (mvld_q & mclip);
      end
      unique case (cmd_i.alu_dst)
        DST_SUM:   sum_q  <= alu_res;
        DST_FORCE: frc_q  <= alu_res;
        DST_VEL:   vel_q  <= alu_res;
        DST_DISP:  disp_q <= alu_res;
        default:   ;
      endcase
    end
  end

endmodule

[hdl/pid_mass_spring_sim_step.sv]
// PID control of a mass-spring-damper, one Euler step per input beat.
// Depends on pms_pkg, pms_if, pms_regs, pms_ctrl and pms_dp.
//
// Use: each input beat on in_i carries a Q16.16 setpoint offset. The block
// runs one closed-loop step (error sum, PID drive, first-order actuator,
// velocity and displacement update) and returns one result beat on out_o
// with the drive, the new displacement and a flag set when any value
// clipped during the step.
// Schedule: an item steps through the sequencer states from the accepting
// edge until the result is registered on out_o; the next beat is accepted
// only once the sequencer is back in idle, so items never overlap. The
// schedule is set by the eight products through one shared two-stage
// multiplier and the chain of dependent saturating adds on the single adder.
// Stalls: a finished result waits in the output register while the next
// item is taken and worked on; that item holds in its last step until the
// register is taken.
// Reset: clears displacement, velocity, actuator force and error sum to
// zero and loads the register defaults. Gains are to be written through the
// APB-style port only while the block is idle; the block does not enforce it.
module pid_mass_spring_sim_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pms_in_if.sink                    in_i,
  pms_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pms_pkg::AddrW-1:0] paddr,
  input  logic [pms_pkg::DataW-1:0] pwdata,
  output logic [pms_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import pms_pkg::*;

  gains_t  gains;
  dp_cmd_t cmd;

  // configuration registers
  pms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  // step sequencer
  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  pms_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .gains_i            (gains),
    .target_offset_i    (in_i.target_offset),
    .drive_value_o      (out_o.drive_value),
    .displacement_out_o (out_o.displacement_out),
    .saturated_o        (out_o.saturated)
  );

  // a taken beat leaves the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a step is under way");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_o.valid)
    else $error("loaded result not offered");

  // an item start never shares its command with a multiplier start or a result load
  a_start_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !cmd.mul_go && !cmd.out_load)
    else $error("item start overlaps other work");

endmodule
